FILE: hw/rtl/cbms_pkg.sv
// Shared types and constants for the BMS status receiver.
// No dependencies; used by every module of the block.

package cbms_pkg;

  localparam logic       KindFrame    = 1'b0;
  localparam logic       KindTick     = 1'b1;

  localparam logic [10:0] IdStatus    = 11'h1F4;
  localparam logic [10:0] IdCells     = 11'h1F5;

  // floor(p / 1000) == (p * RecipMul) >> RecipShift for p < 2**21
  localparam int unsigned ProdW       = 21;
  localparam int unsigned RecipW      = 22;
  localparam logic [RecipW-1:0] RecipMul = 22'd2147484;
  localparam int unsigned RecipShift  = 31;
  localparam int unsigned PowerW      = 12;

  localparam logic [7:0]  TimeoutReset   = 8'd10;
  localparam logic [11:0] TicksPerSecond = 12'd10;
  localparam logic [10:0] SwitchOffset   = 11'd30;
  localparam logic [10:0] SwitchSafe     = 11'd500;

  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_STATUS,
    OP_CELLS
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [1:0]         cnt;
    logic [9:0]         soc;
    logic [15:0]        cur;
    logic [9:0]         volts;
    logic [10:0]        chg;
    logic [PowerW-1:0]  pin;
    logic [PowerW-1:0]  pout;
    logic [12:0]        min_cell;
    logic [12:0]        max_cell;
    logic [7:0]         min_temp;
    logic [7:0]         max_temp;
  } cmd_t;

endpackage

FILE: hw/rtl/cbms_front.sv
// Front end: accepts words, classifies them, extracts fields and computes
// the power limits in two multiplier stages. Depends on cbms_pkg.

module cbms_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [10:0]       frame_id_i,
  input  logic [63:0]       frame_data_i,
  input  logic              full_i,
  output logic              push_o,
  output cbms_pkg::cmd_t    cmd_o
);

  logic                          accept;
  logic                          known;
  cbms_pkg::op_e                 op_in;
  logic [cbms_pkg::ProdW-1:0]    pchg_in;
  logic [cbms_pkg::ProdW-1:0]    pdis_in;

  logic                          s1_valid_q;
  cbms_pkg::op_e                 s1_op_q;
  logic [63:0]                   s1_data_q;
  logic [cbms_pkg::ProdW-1:0]    s1_pchg_q;
  logic [cbms_pkg::ProdW-1:0]    s1_pdis_q;

  logic                          s2_valid_q;
  cbms_pkg::cmd_t                s2_cmd_q;
  cbms_pkg::cmd_t                s2_cmd_d;
  logic                          s2_free;

  logic [cbms_pkg::ProdW+cbms_pkg::RecipW-1:0] qchg;
  logic [cbms_pkg::ProdW+cbms_pkg::RecipW-1:0] qdis;

  assign push_o     = s2_valid_q && !full_i;
  assign s2_free    = !s2_valid_q || !full_i;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd_o      = s2_cmd_q;

  always_comb begin
    known = 1'b1;
    op_in = cbms_pkg::OP_TICK;
    if (kind_i == cbms_pkg::KindTick) begin
      op_in = cbms_pkg::OP_TICK;
    end else if (frame_id_i == cbms_pkg::IdStatus) begin
      op_in = cbms_pkg::OP_STATUS;
    end else if (frame_id_i == cbms_pkg::IdCells) begin
      op_in = cbms_pkg::OP_CELLS;
    end else begin
      known = 1'b0;
    end
  end

  assign pchg_in = cbms_pkg::ProdW'(frame_data_i[10:0]) *
                   cbms_pkg::ProdW'(frame_data_i[57:48]);
  assign pdis_in = cbms_pkg::ProdW'(frame_data_i[21:11]) *
                   cbms_pkg::ProdW'(frame_data_i[57:48]);

  assign qchg = (cbms_pkg::ProdW + cbms_pkg::RecipW)'(s1_pchg_q) *
                (cbms_pkg::ProdW + cbms_pkg::RecipW)'(cbms_pkg::RecipMul);
  assign qdis = (cbms_pkg::ProdW + cbms_pkg::RecipW)'(s1_pdis_q) *
                (cbms_pkg::ProdW + cbms_pkg::RecipW)'(cbms_pkg::RecipMul);

  always_comb begin
    s2_cmd_d          = '0;
    s2_cmd_d.op       = s1_op_q;
    s2_cmd_d.cnt      = s1_data_q[63:62];
    s2_cmd_d.soc      = s1_data_q[31:22];
    s2_cmd_d.cur      = s1_data_q[47:32];
    s2_cmd_d.volts    = s1_data_q[57:48];
    s2_cmd_d.chg      = s1_data_q[10:0];
    s2_cmd_d.pin      = qchg[cbms_pkg::RecipShift +: cbms_pkg::PowerW];
    s2_cmd_d.pout     = qdis[cbms_pkg::RecipShift +: cbms_pkg::PowerW];
    s2_cmd_d.min_cell = s1_data_q[12:0];
    s2_cmd_d.max_cell = s1_data_q[28:16];
    s2_cmd_d.min_temp = s1_data_q[55:48];
    s2_cmd_d.max_temp = s1_data_q[63:56];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= accept && known;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= op_in;
      s1_data_q <= frame_data_i;
      s1_pchg_q <= pchg_in;
      s1_pdis_q <= pdis_in;
    end
    if (s2_free && s1_valid_q) begin
      s2_cmd_q <= s2_cmd_d;
    end
  end

endmodule

FILE: hw/rtl/cbms_queue.sv
// Short command queue between front and back end.
// Depends on cbms_pkg for the command type.

module cbms_queue #(
  parameter int unsigned Depth = cbms_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cbms_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cbms_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cbms_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hw/rtl/cbms_back.sv
// Back end: holds the BMS values and the silence timeout, applies frames
// and answers ticks through the output register. Depends on cbms_pkg.

module cbms_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic                          empty_i,
  input  cbms_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [12:0]                   min_cell_mv_o,
  output logic [12:0]                   max_cell_mv_o,
  output logic signed [7:0]             min_temp_c_o,
  output logic signed [7:0]             max_temp_c_o,
  output logic [9:0]                    soc_tenths_o,
  output logic [9:0]                    pack_volts_o,
  output logic signed [15:0]            current_tenths_o,
  output logic signed [10:0]            switch_volts_o,
  output logic [cbms_pkg::PowerW-1:0]   max_input_kw_o,
  output logic [cbms_pkg::PowerW-1:0]   max_output_kw_o,
  output logic [10:0]                   charge_limit_amps_o,
  output logic                          data_valid_o
);

  logic [7:0]                 timeout_s_q;
  logic [1:0]                 roll_q;
  logic [11:0]                ticks_q, ticks_d;
  logic [11:0]                reload;
  logic                       live;
  logic                       out_free;
  logic                       do_tick;

  logic [9:0]                 soc_q, volts_q;
  logic [15:0]                cur_q;
  logic [10:0]                chg_q;
  logic [cbms_pkg::PowerW-1:0] pin_q, pout_q;
  logic [12:0]                min_cell_q, max_cell_q;
  logic [7:0]                 min_temp_q, max_temp_q;

  logic                       out_valid_q;
  logic [12:0]                o_min_cell_q, o_max_cell_q;
  logic [7:0]                 o_min_temp_q, o_max_temp_q;
  logic [9:0]                 o_soc_q, o_volts_q;
  logic [15:0]                o_cur_q;
  logic [10:0]                o_switch_q;
  logic [cbms_pkg::PowerW-1:0] o_pin_q, o_pout_q;
  logic [10:0]                o_chg_q;
  logic                       o_live_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = !empty_i && ((cmd_i.op != cbms_pkg::OP_TICK) || out_free);
  assign do_tick  = pop_o && (cmd_i.op == cbms_pkg::OP_TICK);
  assign reload   = 12'(timeout_s_q) * cbms_pkg::TicksPerSecond;
  assign ticks_d  = (ticks_q != '0) ? ticks_q - 1'b1 : '0;
  assign live     = (ticks_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_s_q <= cbms_pkg::TimeoutReset;
      roll_q      <= '0;
      ticks_q     <= '0;
      soc_q       <= '0;
      cur_q       <= '0;
      volts_q     <= '0;
      chg_q       <= '0;
      pin_q       <= '0;
      pout_q      <= '0;
      min_cell_q  <= '0;
      max_cell_q  <= '0;
      min_temp_q  <= '0;
      max_temp_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_s_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        unique case (cmd_i.op)
          cbms_pkg::OP_TICK: begin
            ticks_q <= ticks_d;
          end
          cbms_pkg::OP_STATUS: begin
            if (cmd_i.cnt != roll_q) begin
              roll_q  <= cmd_i.cnt;
              ticks_q <= reload;
            end
            soc_q   <= cmd_i.soc;
            cur_q   <= cmd_i.cur;
            volts_q <= cmd_i.volts;
            chg_q   <= cmd_i.chg;
            pin_q   <= cmd_i.pin;
            pout_q  <= cmd_i.pout;
          end
          cbms_pkg::OP_CELLS: begin
            min_cell_q <= cmd_i.min_cell;
            max_cell_q <= cmd_i.max_cell;
            min_temp_q <= cmd_i.min_temp;
            max_temp_q <= cmd_i.max_temp;
          end
          default: begin
          end
        endcase
      end
      if (do_tick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_tick) begin
      o_min_cell_q <= min_cell_q;
      o_max_cell_q <= max_cell_q;
      o_min_temp_q <= min_temp_q;
      o_max_temp_q <= max_temp_q;
      o_soc_q      <= soc_q;
      o_volts_q    <= volts_q;
      o_cur_q      <= live ? cur_q : '0;
      o_switch_q   <= live ? {1'b0, volts_q} - cbms_pkg::SwitchOffset : cbms_pkg::SwitchSafe;
      o_pin_q      <= live ? pin_q : '0;
      o_pout_q     <= live ? pout_q : '0;
      o_chg_q      <= live ? chg_q : '0;
      o_live_q     <= live;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign min_cell_mv_o       = o_min_cell_q;
  assign max_cell_mv_o       = o_max_cell_q;
  assign min_temp_c_o        = o_min_temp_q;
  assign max_temp_c_o        = o_max_temp_q;
  assign soc_tenths_o        = o_soc_q;
  assign pack_volts_o        = o_volts_q;
  assign current_tenths_o    = o_cur_q;
  assign switch_volts_o      = o_switch_q;
  assign max_input_kw_o      = o_pin_q;
  assign max_output_kw_o     = o_pout_q;
  assign charge_limit_amps_o = o_chg_q;
  assign data_valid_o        = o_live_q;

endmodule

FILE: hw/rtl/can_bms_status_receiver.sv
// BMS status receiver top level: front end, command queue, back end.
// Depends on cbms_pkg, cbms_front, cbms_queue and cbms_back.
//
// Takes one word per clock, either a received CAN frame or a 100 ms tick,
// with no gaps needed between them. Frames 0x1F4 and 0x1F5 update the
// stored BMS values; other identifiers are dropped. Each tick counts the
// silence timeout down and returns one result word with every value, the
// current, power and charge limits and the switch voltage forced to safe
// values once the timeout has run out. The front end computes the power
// limits in registered steps (limit times volts, then a reciprocal
// multiply for the divide by 1000); a tick's result then passes through
// the queue and the back end's output register. The sustained rate is one
// word a cycle, lower only while the output side holds off results.
// timeout_seconds is written through cfg_we_i / cfg_wdata_i and resets to 10.

module can_bms_status_receiver #(
  parameter int unsigned QueueDepth = cbms_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [10:0]                   frame_id_i,
  input  logic [63:0]                   frame_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [12:0]                   min_cell_mv_o,
  output logic [12:0]                   max_cell_mv_o,
  output logic signed [7:0]             min_temp_c_o,
  output logic signed [7:0]             max_temp_c_o,
  output logic [9:0]                    soc_tenths_o,
  output logic [9:0]                    pack_volts_o,
  output logic signed [15:0]            current_tenths_o,
  output logic signed [10:0]            switch_volts_o,
  output logic [cbms_pkg::PowerW-1:0]   max_input_kw_o,
  output logic [cbms_pkg::PowerW-1:0]   max_output_kw_o,
  output logic [10:0]                   charge_limit_amps_o,
  output logic                          data_valid_o
);

  logic           push, full, pop, empty;
  cbms_pkg::cmd_t push_cmd, head_cmd;

  cbms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .frame_id_i   (frame_id_i),
    .frame_data_i (frame_data_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  cbms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  cbms_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .empty_i             (empty),
    .cmd_i               (head_cmd),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .min_cell_mv_o       (min_cell_mv_o),
    .max_cell_mv_o       (max_cell_mv_o),
    .min_temp_c_o        (min_temp_c_o),
    .max_temp_c_o        (max_temp_c_o),
    .soc_tenths_o        (soc_tenths_o),
    .pack_volts_o        (pack_volts_o),
    .current_tenths_o    (current_tenths_o),
    .switch_volts_o      (switch_volts_o),
    .max_input_kw_o      (max_input_kw_o),
    .max_output_kw_o     (max_output_kw_o),
    .charge_limit_amps_o (charge_limit_amps_o),
    .data_valid_o        (data_valid_o)
  );

endmodule

FILE: hw/rtl/cbms_checker.sv
// Port-level checks for the BMS status receiver, bound to the top level.
// Depends on cbms_pkg and can_bms_status_receiver.

module cbms_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [9:0]                  pack_volts_o,
  input logic signed [15:0]          current_tenths_o,
  input logic signed [10:0]          switch_volts_o,
  input logic [cbms_pkg::PowerW-1:0] max_input_kw_o,
  input logic [cbms_pkg::PowerW-1:0] max_output_kw_o,
  input logic [10:0]                 charge_limit_amps_o,
  input logic                        data_valid_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_valid_o) &&
      $stable(switch_volts_o) && $stable(max_input_kw_o))
    else $error("result changed while stalled");

  a_safe_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_valid_o |-> current_tenths_o == 16'sd0 &&
      switch_volts_o == cbms_pkg::SwitchSafe && max_input_kw_o == '0 &&
      max_output_kw_o == '0 && charge_limit_amps_o == '0)
    else $error("expired timeout without safe values");

  a_switch_volts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_valid_o |->
      switch_volts_o == ({1'b0, pack_volts_o} - cbms_pkg::SwitchOffset))
    else $error("switch voltage not pack volts minus offset");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> max_input_kw_o <= 12'd2094 && max_output_kw_o <= 12'd2094)
    else $error("power limit out of range");

endmodule

bind can_bms_status_receiver cbms_checker u_cbms_checker (.*);
